FILE: rtl/core/knp_pkg.sv
// knp_pkg: shared widths, register codes and payload types for the
// k-nearest point selection block. No dependencies.

package knp_pkg;

	localparam int MAX_K_DEF = 16;

	localparam int ID_W      = 16;
	localparam int COORD_W   = 24;
	localparam int DIST_W    = 50;
	localparam int NC_W      = 5;
	localparam int REG_IDX_W = 3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_QUERY_X        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_QUERY_Y        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_QUERY_Z        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 3'd3;

	localparam logic [NC_W-1:0] NEIGHBOR_COUNT_RST = 5'd1;

	typedef struct packed {
		logic [ID_W-1:0]           node_id;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      final_point;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] chosen_id;
		logic            end_of_list;
	} out_item_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] reg_index;
		logic [COORD_W-1:0]   wdata;
	} cfg_write_t;

	// operands of one distance request
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
		logic signed [COORD_W-1:0] qz;
	} dist_req_t;

	// one kept list entry as stored in memory
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_sq;
	} entry_t;

endpackage

FILE: rtl/core/knp_ram.sv
// knp_ram: generic single write port, single read port memory with a
// registered read. No dependencies.

module knp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/knp_dist.sv
// knp_dist: squared distance unit, one axis per cycle through a shared
// 25x25 multiplier, abs / square / accumulate stages. Depends on knp_pkg.

module knp_dist
	import knp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dist_req_t         req,
	output logic              done,
	output logic [DIST_W-1:0] dist_sq
);

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	logic                  iss_q;
	logic [1:0]            ax_q;
	logic                  v_s1, last_s1;
	logic                  v_s2, last_s2;
	logic                  done_q;
	logic [COORD_W:0]      mag_s1;
	logic [2*COORD_W+1:0]  sq_s2;
	logic [DIST_W-1:0]     acc_q;

	logic signed [COORD_W-1:0] a_sel, b_sel;
	logic signed [COORD_W:0]   diff;
	logic [COORD_W:0]          mag;

	always_comb begin
		case (ax_q)
			AX_X: begin
				a_sel = req.px;
				b_sel = req.qx;
			end
			AX_Y: begin
				a_sel = req.py;
				b_sel = req.qy;
			end
			default: begin
				a_sel = req.pz;
				b_sel = req.qz;
			end
		endcase
		diff = {a_sel[COORD_W-1], a_sel} - {b_sel[COORD_W-1], b_sel};
		// most negative difference is -(2^24 - 1), so its magnitude fits as unsigned
		mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= 1'b0;
			ax_q    <= AX_X;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				iss_q <= 1'b1;
				ax_q  <= AX_X;
			end else if (iss_q) begin
				ax_q <= ax_q + 2'd1;
				if (ax_q == AX_Z) begin
					iss_q <= 1'b0;
				end
			end
			v_s1    <= iss_q;
			last_s1 <= (ax_q == AX_Z);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (start) begin
				done_q <= 1'b0;
			end else if (v_s2 && last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		sq_s2  <= mag_s1 * mag_s1;
		if (start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + sq_s2;
		end
	end

	assign done    = done_q;
	assign dist_sq = acc_q;

endmodule

FILE: rtl/core/k_nearest_point_selection.sv
// k_nearest_point_selection: top level, list control sequencer around the
// entry memory and the distance unit. Depends on knp_pkg, knp_ram, knp_dist.

// Candidate points stream in as requests (node id, signed Q20.4 x/y/z,
// final flag); the block keeps up to k = min(neighbor_count, MAX_K) node ids
// in one memory of {id, squared distance} entries. One request is worked on
// at a time. While the list is short the point is appended once the
// distance unit is done, which squares one axis per cycle through one
// 25x25 multiplier. Once full, the list is scanned one memory read per cycle
// for the first strictly farthest entry, and on a strictly closer candidate
// the later entries are moved up one place (one read and one write per
// cycle) and the candidate is written at the tail; for three or more kept
// entries the update time is set by the single memory read port, and
// shorter lists are bound by the distance unit. On a request flagged
// final_point the kept ids go out in list order, with at most one memory
// read in flight, end_of_list on the last, and the list is emptied; a new
// request is taken while the last result still sits in the output register.
// Configuration writes are accepted every cycle and must only be issued
// while the block is idle. Out-of-range register indexes are ignored.

module k_nearest_point_selection
	import knp_pkg::*;
#(
	parameter int MAX_K = MAX_K_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_write_t cfg_write
);

	localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int CW = $clog2(MAX_K + 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_CHOOSE    = 4'd1;
	localparam logic [3:0] ST_APPEND    = 4'd2;
	localparam logic [3:0] ST_SCAN      = 4'd3;
	localparam logic [3:0] ST_SCAN_WAIT = 4'd4;
	localparam logic [3:0] ST_SHIFT     = 4'd5;
	localparam logic [3:0] ST_TAIL      = 4'd6;
	localparam logic [3:0] ST_FINISH    = 4'd7;
	localparam logic [3:0] ST_EMIT      = 4'd8;

	// what an outstanding memory read is for
	localparam logic [1:0] RK_SCAN  = 2'd0;
	localparam logic [1:0] RK_SHIFT = 2'd1;
	localparam logic [1:0] RK_EMIT  = 2'd2;

	logic [3:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;
	logic [DIST_W-1:0]  worst_q;
	logic [AW-1:0]      at_q;
	logic               found_q;
	in_item_t           item_q;

	// configuration
	logic signed [COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [NC_W-1:0]           nc_q;

	// read tag, registered so that it lines up with the memory read data
	logic          rd_v_s1;
	logic [1:0]    rd_kind_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_last_s1;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// memory ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	// distance unit
	logic              dist_start, dist_done;
	logic [DIST_W-1:0] cand_dist;
	dist_req_t         dreq;

	logic [CW-1:0] k_lim;
	logic [CW-1:0] cnt_m1;
	logic          in_acc;
	logic          scan_hit;
	logic [1:0]    rd_kind;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// k saturates at the list depth
	assign k_lim  = (int'(nc_q) > MAX_K) ? CW'(MAX_K) : CW'(nc_q);
	assign cnt_m1 = count_q - CW'(1);

	assign dist_start = in_acc;
	assign dreq = '{px: item_q.pos_x, py: item_q.pos_y, pz: item_q.pos_z,
	                qx: qx_q, qy: qy_q, qz: qz_q};

	knp_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dist_start),
		.req     (dreq),
		.done    (dist_done),
		.dist_sq (cand_dist)
	);

	knp_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_K)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = '{id: item_q.node_id, dist_sq: cand_dist};
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		rd_kind   = RK_SCAN;
		case (state_q)
			ST_APPEND: begin
				if (dist_done) begin
					ram_we = 1'b1;
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
			end
			ST_SHIFT: begin
				rd_kind = RK_SHIFT;
				if (ptr_q < count_q) begin
					ram_re = 1'b1;
				end
			end
			ST_TAIL: begin
				// interlock: wait for the last move-up write to land
				ram_waddr = cnt_m1[AW-1:0];
				if (!rd_v_s1) begin
					ram_we = 1'b1;
				end
			end
			ST_EMIT: begin
				rd_kind = RK_EMIT;
				// one read in flight at most, and only into a free output slot
				if (ptr_q != count_q && (!out_valid_q || out_ready) && !rd_v_s1) begin
					ram_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// move-up: the entry read last cycle goes one place toward the head
		if (rd_v_s1 && rd_kind_s1 == RK_SHIFT) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_s1 - AW'(1);
			ram_wdata = ram_rdata;
		end
	end

	assign scan_hit = rd_v_s1 && rd_kind_s1 == RK_SCAN && ram_rdata.dist_sq > worst_q;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			worst_q     <= '0;
			at_q        <= '0;
			found_q     <= 1'b0;
			rd_v_s1     <= 1'b0;
			rd_kind_s1  <= RK_SCAN;
			rd_addr_s1  <= '0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			qx_q        <= '0;
			qy_q        <= '0;
			qz_q        <= '0;
			nc_q        <= NEIGHBOR_COUNT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_write.reg_index)
					REG_QUERY_X:        qx_q <= cfg_write.wdata;
					REG_QUERY_Y:        qy_q <= cfg_write.wdata;
					REG_QUERY_Z:        qz_q <= cfg_write.wdata;
					REG_NEIGHBOR_COUNT: nc_q <= cfg_write.wdata[NC_W-1:0];
					default: begin
					end
				endcase
			end

			rd_v_s1    <= ram_re;
			rd_kind_s1 <= rd_kind;
			rd_addr_s1 <= ram_raddr;
			rd_last_s1 <= (ptr_q == cnt_m1);

			// farthest entry: first one strictly above everything before it
			if (scan_hit) begin
				worst_q <= ram_rdata.dist_sq;
				at_q    <= rd_addr_s1;
				found_q <= 1'b1;
			end

			if (rd_v_s1 && rd_kind_s1 == RK_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CHOOSE;
					end
				end
				ST_CHOOSE: begin
					ptr_q   <= '0;
					worst_q <= '0;
					found_q <= 1'b0;
					if (count_q < k_lim) begin
						state_q <= ST_APPEND;
					end else if (count_q != '0) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_APPEND: begin
					if (dist_done) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + CW'(1);
					if (ptr_q == cnt_m1) begin
						state_q <= ST_SCAN_WAIT;
					end
				end
				ST_SCAN_WAIT: begin
					if (!rd_v_s1 && dist_done) begin
						if (found_q && cand_dist < worst_q) begin
							ptr_q   <= CW'(at_q) + CW'(1);
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SHIFT: begin
					if (ptr_q < count_q) begin
						ptr_q <= ptr_q + CW'(1);
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (!rd_v_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					ptr_q <= '0;
					if (item_q.final_point) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (ptr_q == count_q) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end else if (ram_re) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_item;
		end
		if (rd_v_s1 && rd_kind_s1 == RK_EMIT) begin
			out_q <= '{chosen_id: ram_rdata.id, end_of_list: rd_last_s1};
		end
	end

`ifndef SYNTHESIS
	// list never grows past the memory depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_K))
		else $error("kept count above list depth");

	// an emitted entry never lands on a result that is still waiting
	a_emit_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && rd_kind_s1 == RK_EMIT) |-> (!out_valid_q || out_ready))
		else $error("output register overrun");

	// move-up never targets below the head of the list
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && rd_kind_s1 == RK_SHIFT) |-> (rd_addr_s1 != '0))
		else $error("move-up from list head");

	// the memory is only written while a request is being worked on
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != ST_IDLE && state_q != ST_EMIT))
		else $error("memory write outside list update");

	// finishing the emit empties the list before the next request
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && ptr_q == count_q) |=> (count_q == '0 && state_q == ST_IDLE))
		else $error("list not emptied after emit");
`endif

endmodule

FILE: bench/knp_list_checker.sv
`timescale 1ns / 100ps
// knp_list_checker: watches the request, result and register write channels
// of the k-nearest point selection block, predicts the kept list and checks
// every result. Depends on knp_pkg.

module knp_list_checker
	import knp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_item_t   in_item,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_item_t  out_item,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  cfg_write_t cfg_write,
	output int         fail_count,
	output int         pending_results
);

	logic signed [COORD_W-1:0] qry_x;
	logic signed [COORD_W-1:0] qry_y;
	logic signed [COORD_W-1:0] qry_z;
	logic [NC_W-1:0]           keep_req;

	logic [ID_W-1:0]   list_id   [MAX_K_DEF];
	logic [DIST_W-1:0] list_dist [MAX_K_DEF];
	int                list_len;

	out_item_t chosen_q [$];
	int        errors;

	// exact squared distance to the query point
	function automatic logic [DIST_W-1:0] sq_dist(in_item_t p);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'($signed(p.pos_x)) - longint'(qry_x);
		dy = longint'($signed(p.pos_y)) - longint'(qry_y);
		dz = longint'($signed(p.pos_z)) - longint'(qry_z);
		return DIST_W'(dx * dx + dy * dy + dz * dz);
	endfunction

	task automatic take_point(in_item_t p);
		int                k;
		int                at;
		bit                found;
		logic [DIST_W-1:0] d;
		logic [DIST_W-1:0] worst;
		out_item_t         r;
		k = (keep_req > MAX_K_DEF) ? MAX_K_DEF : int'(keep_req);
		d = sq_dist(p);
		if (list_len < k) begin
			list_id[list_len] = p.node_id;
			list_dist[list_len] = d;
			list_len++;
		end else if (list_len > 0) begin
			// farthest = first entry strictly above everything before it
			worst = '0;
			at = 0;
			found = 1'b0;
			for (int i = 0; i < list_len; i++) begin
				if (list_dist[i] > worst) begin
					worst = list_dist[i];
					at = i;
					found = 1'b1;
				end
			end
			if (found && d < worst) begin
				for (int i = at; i + 1 < list_len; i++) begin
					list_id[i] = list_id[i + 1];
					list_dist[i] = list_dist[i + 1];
				end
				list_id[list_len - 1] = p.node_id;
				list_dist[list_len - 1] = d;
			end
		end
		if (p.final_point) begin
			for (int i = 0; i < list_len; i++) begin
				r.chosen_id = list_id[i];
				r.end_of_list = (i + 1 == list_len);
				chosen_q.push_back(r);
			end
			list_len = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			qry_x = '0;
			qry_y = '0;
			qry_z = '0;
			keep_req = NEIGHBOR_COUNT_RST;
			list_len = 0;
			chosen_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_write.reg_index)
					REG_QUERY_X: qry_x = $signed(cfg_write.wdata);
					REG_QUERY_Y: qry_y = $signed(cfg_write.wdata);
					REG_QUERY_Z: qry_z = $signed(cfg_write.wdata);
					REG_NEIGHBOR_COUNT: keep_req = cfg_write.wdata[NC_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_point(in_item);
			if (out_valid && out_ready) begin
				if (chosen_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual chosen_id %0d end_of_list %0b",
						$time, out_item.chosen_id, out_item.end_of_list);
				end else begin
					want = chosen_q.pop_front();
					if (out_item.chosen_id !== want.chosen_id) begin
						errors++;
						$display("%0t: chosen_id mismatch, expected %0d actual %0d",
							$time, want.chosen_id, out_item.chosen_id);
					end
					if (out_item.end_of_list !== want.end_of_list) begin
						errors++;
						$display("%0t: end_of_list mismatch, expected %0b actual %0b",
							$time, want.end_of_list, out_item.end_of_list);
					end
				end
			end
		end
		fail_count <= errors;
		pending_results <= chosen_q.size();
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for the k-nearest point selection block.
// Depends on knp_pkg, k_nearest_point_selection and knp_list_checker.

module tb;
	import knp_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 60;   // full scan plus shift of a 16 entry list
	localparam int RANDOM_POINTS = 230;
	localparam int QUIET_POINTS  = 40;   // tail of the run with no idling

	localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
	localparam logic [COORD_W-1:0] C_MIN = 24'h800000;
	localparam logic [COORD_W-1:0] C_NEG1 = 24'hFFFFFF;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_write_t cfg_write;

	int fail_count;
	int pending_results;
	int cycle_cnt;
	int points_sent;
	bit quiet;

	// query of the current phase, used as the center of clustered points
	logic [COORD_W-1:0] cur_qx;
	logic [COORD_W-1:0] cur_qy;
	logic [COORD_W-1:0] cur_qz;

	k_nearest_point_selection u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_write(cfg_write)
	);

	knp_list_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_write      (cfg_write),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit, counted in clock cycles
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Some tests failed");
		$finish;
	end

	// result side back-pressure: random stall bursts, none in the quiet tail
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 9) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic in_item_t point(logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic fin);
		in_item_t p;
		p.node_id = id;
		p.pos_x = x;
		p.pos_y = y;
		p.pos_z = z;
		p.final_point = fin;
		return p;
	endfunction

	// mix of full range, tight clusters around the query (ties), and extremes
	function automatic logic [COORD_W-1:0] rand_coord(logic [COORD_W-1:0] center);
		logic [COORD_W-1:0] v;
		int                 off;
		case ($urandom_range(0, 9))
			0, 1, 2: v = COORD_W'($urandom);
			3, 4, 5: begin
				off = $urandom_range(0, 8);
				v = center + COORD_W'(off - 4);
			end
			6, 7: begin
				off = $urandom_range(0, 4000);
				v = center + COORD_W'(off - 2000);
			end
			8: begin
				case ($urandom_range(0, 3))
					0: v = C_MAX;
					1: v = C_MIN;
					2: v = '0;
					default: v = C_NEG1;
				endcase
			end
			default: v = center;
		endcase
		return v;
	endfunction

	// small pool of ids so that repeats show up in the list
	function automatic logic [ID_W-1:0] rand_id();
		logic [ID_W-1:0] id;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: id = ID_W'($urandom);
			5, 6, 7: id = ID_W'($urandom_range(0, 7));
			8: id = '0;
			default: id = '1;
		endcase
		return id;
	endfunction

	// one request; valid is left high, the next call or a pause lowers it
	task automatic send_point(in_item_t p);
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		points_sent++;
	endtask

	// one register write; cfg_valid stays high until the caller lowers it
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
		cfg_write_t w;
		w.reg_index = idx;
		w.wdata = data;
		cfg_valid <= 1'b1;
		cfg_write <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		write_reg(REG_QUERY_X, x);
		write_reg(REG_QUERY_Y, y);
		write_reg(REG_QUERY_Z, z);
		cur_qx = x;
		cur_qy = y;
		cur_qz = z;
	endtask

	// upper data bits are junk, only the low count bits matter
	task automatic set_count(logic [NC_W-1:0] k);
		logic [COORD_W-1:0] data;
		data = COORD_W'($urandom);
		data[NC_W-1:0] = k;
		write_reg(REG_NEIGHBOR_COUNT, data);
	endtask

	// block idle: all results in, then time for a scan that yields none
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int              end_mark;
		int              len;
		int              cut;
		logic [NC_W-1:0] k;
		logic [NC_W-1:0] new_k;

		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_write = '0;
		arst_n = 1'b0;
		quiet = 1'b0;
		points_sent = 0;
		cur_qx = '0;
		cur_qy = '0;
		cur_qz = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, keep one: origin point wins, zero distance ties keep it,
		// and with every kept distance zero nothing can be replaced
		send_point(point(16'hFFFF, C_MAX, C_MIN, C_MAX, 1'b0));
		send_point(point(16'h0000, '0, '0, '0, 1'b0));
		send_point(point(16'h0001, '0, '0, '0, 1'b0));
		send_point(point(16'h0002, 24'h000001, '0, '0, 1'b1));
		settle();

		// writes to unused register slots are dropped; keep none
		write_reg(REG_NEIGHBOR_COUNT + 3'd1, COORD_W'($urandom));
		write_reg(REG_NEIGHBOR_COUNT + 3'd4, C_NEG1);
		set_query(C_MIN, C_MAX, 24'h000001);
		set_count(5'd0);
		cfg_valid <= 1'b0;
		send_point(point(16'h0005, C_MAX, C_MIN, C_NEG1, 1'b0));
		send_point(point(16'h0006, '0, '0, '0, 1'b1));
		settle();

		// keep three around (1.0, 1.0, 1.0): equal distance, repeated ids,
		// then the count lowered with the list already full
		set_query(24'd16, 24'd16, 24'd16);
		set_count(5'd3);
		cfg_valid <= 1'b0;
		send_point(point(16'd7, 24'd16, 24'd16, 24'd48, 1'b0));
		send_point(point(16'd7, 24'd16, 24'd16, 24'd80, 1'b0));
		send_point(point(16'd9, 24'd16, 24'd48, 24'd16, 1'b0));
		send_point(point(16'd10, 24'd80, 24'd16, 24'd16, 1'b0));
		send_point(point(16'd7, 24'd16, 24'd16, 24'd32, 1'b0));
		settle();
		set_count(5'd1);
		cfg_valid <= 1'b0;
		send_point(point(16'd11, 24'd16, 24'd16, 24'd0, 1'b0));
		send_point(point(16'd12, 24'd16, 24'd16, 24'd16, 1'b1));
		settle();

		// count above the maximum, largest possible distances
		set_query(C_MIN, C_MIN, C_MIN);
		set_count(5'd31);
		cfg_valid <= 1'b0;
		send_point(point(16'hFFFF, C_MAX, C_MAX, C_MAX, 1'b0));
		send_point(point(16'hAAAA, C_MIN, C_MIN, C_MIN, 1'b0));
		send_point(point(16'h5555, C_NEG1, '0, C_MAX, 1'b1));
		settle();

		// random sets, each with its own settings
		end_mark = points_sent + RANDOM_POINTS;
		while (points_sent < end_mark) begin
			settle();
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 4))
					0: set_query(($urandom_range(0, 1) != 0) ? C_MAX : C_MIN,
						($urandom_range(0, 1) != 0) ? C_MAX : C_MIN,
						($urandom_range(0, 1) != 0) ? C_MAX : C_MIN);
					1: set_query(COORD_W'($urandom_range(0, 200)) - 24'd100,
						COORD_W'($urandom_range(0, 200)) - 24'd100,
						COORD_W'($urandom_range(0, 200)) - 24'd100);
					default: set_query(COORD_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom));
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_NEIGHBOR_COUNT + REG_IDX_W'($urandom_range(1, 4)),
					COORD_W'($urandom));
			case ($urandom_range(0, 19))
				0: k = 5'd0;
				1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: k = NC_W'($urandom_range(1, 6));
				13, 14, 15: k = NC_W'($urandom_range(7, 15));
				16, 17: k = 5'd16;
				default: k = NC_W'($urandom_range(17, 31));
			endcase
			set_count(k);
			cfg_valid <= 1'b0;

			len = (k == 0) ? $urandom_range(1, 4) : $urandom_range(1, int'(k) + 12);
			// sometimes lower the count once the list has filled
			cut = (len > int'(k) + 2 && $urandom_range(0, 6) == 0) ? int'(k) + 2 : -1;
			for (int j = 0; j < len; j++) begin
				if (j == cut) begin
					settle();
					new_k = NC_W'($urandom_range(0, int'(k)));
					set_count(new_k);
					cfg_valid <= 1'b0;
				end
				quiet = (points_sent >= end_mark - QUIET_POINTS);
				send_point(point(rand_id(), rand_coord(cur_qx), rand_coord(cur_qy),
					rand_coord(cur_qz), j == len - 1));
			end
		end

		// drain the last results and give stray ones time to show up
		settle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
